### hdl/efsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the extent free-space allocator.
// No dependencies.
package efsa_pkg;

   localparam int ADDR_W = 24;
   localparam int LEN_W  = 25;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_FORMAT  = 2'd2;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NO_SPACE = 3'd1;
   localparam logic [2:0] STATUS_FRAG     = 3'd2;
   localparam logic [2:0] STATUS_RANGE    = 3'd3;
   localparam logic [2:0] STATUS_OVERLAP  = 3'd4;
   localparam logic [2:0] STATUS_FULL     = 3'd5;

   localparam logic [LEN_W-1:0] VOLUME_RESET = 25'd16777216;
   localparam logic [ADDR_W-1:0] FIRST_FREE_RESET = 24'd1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [LEN_W-1:0]  block_count;
      logic [LEN_W-1:0]  min_contiguous;
      logic [ADDR_W-1:0] start_block;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] granted_start;
      logic [LEN_W-1:0]  granted_count;
      logic              last;
      logic [LEN_W-1:0]  free_remaining;
   } rsp_item_type;

   typedef struct packed {
      logic [LEN_W-1:0]  volume_blocks;
      logic [ADDR_W-1:0] first_free_block;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_RELEASE,
      OP_FORMAT,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [LEN_W-1:0]  count;
      logic [LEN_W-1:0]  minc;
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  endx;
   } cmd_type;

endpackage

### hdl/efsa_front.sv
`timescale 1ns / 1ps
// Request front end: decodes request type and range-checks releases.
// Depends on efsa_pkg.
module efsa_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  efsa_pkg::req_item_type req_data,
   input  efsa_pkg::cfg_type     cfg,
   input  logic                  q_ready,
   output logic                  q_push,
   output efsa_pkg::cmd_type     q_cmd
);

   logic [efsa_pkg::LEN_W:0] endx_wide;

   assign endx_wide = {2'b00, req_data.start_block} + {1'b0, req_data.block_count};
   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   always_comb begin
      q_cmd.count = req_data.block_count;
      q_cmd.minc  = req_data.min_contiguous;
      q_cmd.start = req_data.start_block;
      q_cmd.endx  = endx_wide[efsa_pkg::LEN_W-1:0];
      unique case (req_data.req_type)
         efsa_pkg::REQ_ALLOC: q_cmd.op = efsa_pkg::OP_ALLOC;
         efsa_pkg::REQ_RELEASE: begin
            if (endx_wide > {1'b0, cfg.volume_blocks}) q_cmd.op = efsa_pkg::OP_REJECT;
            else q_cmd.op = efsa_pkg::OP_RELEASE;
         end
         efsa_pkg::REQ_FORMAT: q_cmd.op = efsa_pkg::OP_FORMAT;
         default: q_cmd.op = efsa_pkg::OP_REJECT;
      endcase
   end

endmodule

### hdl/efsa_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the table engine.
// Depends on efsa_pkg.
module efsa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  efsa_pkg::cmd_type push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output efsa_pkg::cmd_type pop_cmd
);

   efsa_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

### hdl/efsa_engine.sv
`timescale 1ns / 1ps
// Extent table engine: scans the table, applies allocate, release and format.
// Depends on efsa_pkg.
module efsa_engine #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  efsa_pkg::cfg_type      cfg,
   input  logic                   q_valid,
   input  efsa_pkg::cmd_type      q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output efsa_pkg::rsp_item_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_EXTENTS);
   localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int AW    = efsa_pkg::ADDR_W;
   localparam int LW    = efsa_pkg::LEN_W;

   typedef enum logic [3:0] {
      S_IDLE, S_A1_RD, S_A1_CHK, S_A2_RD, S_A2_CHK,
      S_R_RD, S_R_CHK, S_R_FIN, S_RESULT
   } state_type;

   state_type              state_ff;
   efsa_pkg::cmd_type      cmd_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [LW-1:0]          need_ff;
   logic [LW:0]            sum_ff;
   logic [LW-1:0]          free_ff;
   logic [LW-1:0]          final_free_ff;
   logic [CNT_W-1:0]       entries_ff;
   logic [MAX_EXTENTS-1:0] valid_ff;
   logic [2:0]             status_ff;
   logic                   found_ff;
   logic                   merge_ff;
   logic [IDX_W-1:0]       place_ff;
   logic [LW-1:0]          place_len_ff;
   logic                   rsp_valid_ff;
   efsa_pkg::rsp_item_type rsp_data_ff;

   logic [AW-1:0] start_mem [MAX_EXTENTS];
   logic [LW-1:0] len_mem [MAX_EXTENTS];
   logic [AW-1:0] rd_start_ff;
   logic [LW-1:0] rd_len_ff;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [AW-1:0]    mem_wstart;
   logic [LW-1:0]    mem_wlen;

   logic             entry_valid, usable, out_free, last_entry, fmt_ok, overlap, place_hit;
   logic             rsp_load;
   logic [IDX_W-1:0] last_idx;
   logic [LW:0]      sum_in, rd_end, free_sum;
   logic [LW-1:0]    take, fmt_len, rel_len, free_add;

   assign entry_valid = valid_ff[idx_ff];
   assign usable      = entry_valid && (rd_len_ff != '0) && (rd_len_ff >= cmd_ff.minc);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_load    = out_free && (((state_ff == S_A2_CHK) && usable)
                                     || (state_ff == S_RESULT));
   assign last_idx    = IDX_W'(entries_ff - 1'b1);
   assign last_entry  = (CNT_W'(idx_ff) + 1'b1) == entries_ff;
   assign fmt_ok      = {1'b0, cfg.first_free_block} < cfg.volume_blocks;
   assign fmt_len     = fmt_ok ? cfg.volume_blocks - {1'b0, cfg.first_free_block} : '0;
   assign sum_in      = sum_ff + (usable ? {1'b0, rd_len_ff} : '0);
   assign take        = (rd_len_ff <= need_ff) ? rd_len_ff : need_ff;
   assign rd_end      = {2'b00, rd_start_ff} + {1'b0, rd_len_ff};
   assign overlap     = entry_valid && (rd_len_ff != '0)
                        && ({2'b00, cmd_ff.start} < rd_end)
                        && ({1'b0, rd_start_ff} < cmd_ff.endx);
   assign place_hit   = !entry_valid || ({1'b0, rd_start_ff} == cmd_ff.endx);
   assign rel_len     = (found_ff && merge_ff) ? place_len_ff + cmd_ff.count : cmd_ff.count;
   assign free_sum    = {1'b0, free_ff} + {1'b0, cmd_ff.count};
   assign free_add    = free_sum[LW] ? '1 : free_sum[LW-1:0];
   assign q_pop       = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = idx_ff;
      mem_wstart = cfg.first_free_block;
      mem_wlen   = fmt_len;
      unique case (state_ff)
         S_IDLE: begin
            mem_we    = q_valid && (q_cmd.op == efsa_pkg::OP_FORMAT);
            mem_waddr = '0;
         end
         S_A2_CHK: begin
            mem_we     = usable && out_free && (rd_len_ff > need_ff);
            mem_wstart = rd_start_ff + need_ff[AW-1:0];
            mem_wlen   = rd_len_ff - need_ff;
         end
         S_R_FIN: begin
            mem_we     = found_ff || (entries_ff < CNT_W'(MAX_EXTENTS));
            mem_waddr  = found_ff ? place_ff : IDX_W'(entries_ff);
            mem_wstart = cmd_ff.start;
            mem_wlen   = rel_len;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_waddr] <= mem_wstart;
         len_mem[mem_waddr]   <= mem_wlen;
      end
      rd_start_ff <= start_mem[idx_ff];
      rd_len_ff   <= len_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= '0;
         valid_ff     <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_cmd;
                  found_ff <= 1'b0;
                  unique case (q_cmd.op)
                     efsa_pkg::OP_REJECT: begin
                        status_ff <= efsa_pkg::STATUS_RANGE;
                        state_ff  <= S_RESULT;
                     end
                     efsa_pkg::OP_FORMAT: begin
                        status_ff  <= efsa_pkg::STATUS_OK;
                        state_ff   <= S_RESULT;
                        valid_ff   <= {{(MAX_EXTENTS-1){1'b0}}, fmt_ok};
                        free_ff    <= fmt_len;
                        entries_ff <= CNT_W'(1);
                     end
                     efsa_pkg::OP_ALLOC: begin
                        if (q_cmd.count == '0) begin
                           status_ff <= efsa_pkg::STATUS_OK;
                           state_ff  <= S_RESULT;
                        end else if (q_cmd.count > free_ff || q_cmd.count < q_cmd.minc) begin
                           status_ff <= efsa_pkg::STATUS_NO_SPACE;
                           state_ff  <= S_RESULT;
                        end else if (entries_ff == '0) begin
                           status_ff <= efsa_pkg::STATUS_FRAG;
                           state_ff  <= S_RESULT;
                        end else begin
                           status_ff     <= efsa_pkg::STATUS_OK;
                           idx_ff        <= last_idx;
                           sum_ff        <= '0;
                           need_ff       <= q_cmd.count;
                           final_free_ff <= free_ff - q_cmd.count;
                           state_ff      <= S_A1_RD;
                        end
                     end
                     efsa_pkg::OP_RELEASE: begin
                        status_ff <= efsa_pkg::STATUS_OK;
                        if (q_cmd.count != '0) begin
                           idx_ff   <= '0;
                           state_ff <= (entries_ff == '0) ? S_R_FIN : S_R_RD;
                        end else begin
                           state_ff <= S_RESULT;
                        end
                     end
                     default: begin
                        status_ff <= efsa_pkg::STATUS_RANGE;
                        state_ff  <= S_RESULT;
                     end
                  endcase
               end
            end
            S_A1_RD: state_ff <= S_A1_CHK;
            S_A1_CHK: begin
               sum_ff <= sum_in;
               if (sum_in >= {1'b0, need_ff}) begin
                  idx_ff   <= last_idx;
                  state_ff <= S_A2_RD;
               end else if (idx_ff == '0) begin
                  status_ff <= efsa_pkg::STATUS_FRAG;
                  state_ff  <= S_RESULT;
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= S_A1_RD;
               end
            end
            S_A2_RD: state_ff <= S_A2_CHK;
            S_A2_CHK: begin
               if (!usable) begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= S_A2_RD;
               end else if (out_free) begin
                  rsp_data_ff.status          <= efsa_pkg::STATUS_OK;
                  rsp_data_ff.granted_start   <= rd_start_ff;
                  rsp_data_ff.granted_count   <= take;
                  rsp_data_ff.last            <= rd_len_ff >= need_ff;
                  rsp_data_ff.free_remaining  <= final_free_ff;
                  free_ff                     <= free_ff - take;
                  need_ff                     <= need_ff - take;
                  if (rd_len_ff <= need_ff) valid_ff[idx_ff] <= 1'b0;
                  if (rd_len_ff >= need_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff - 1'b1;
                     state_ff <= S_A2_RD;
                  end
               end
            end
            S_R_RD: state_ff <= S_R_CHK;
            S_R_CHK: begin
               if (overlap) begin
                  status_ff <= efsa_pkg::STATUS_OVERLAP;
                  state_ff  <= S_RESULT;
               end else begin
                  if (!found_ff && place_hit) begin
                     found_ff     <= 1'b1;
                     merge_ff     <= entry_valid;
                     place_ff     <= idx_ff;
                     place_len_ff <= rd_len_ff;
                  end
                  if (last_entry) begin
                     state_ff <= S_R_FIN;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_R_RD;
                  end
               end
            end
            S_R_FIN: begin
               state_ff <= S_RESULT;
               if (found_ff) begin
                  valid_ff[place_ff] <= 1'b1;
                  free_ff            <= free_add;
               end else if (entries_ff < CNT_W'(MAX_EXTENTS)) begin
                  valid_ff[IDX_W'(entries_ff)] <= 1'b1;
                  entries_ff                   <= entries_ff + 1'b1;
                  free_ff                      <= free_add;
               end else begin
                  status_ff <= efsa_pkg::STATUS_FULL;
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_data_ff.status         <= status_ff;
                  rsp_data_ff.granted_start  <= '0;
                  rsp_data_ff.granted_count  <= '0;
                  rsp_data_ff.last           <= 1'b1;
                  rsp_data_ff.free_remaining <= free_ff;
                  state_ff                   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      entries_ff <= CNT_W'(MAX_EXTENTS))
      else $error("table entry count above capacity");

   a_grant_needs_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A2_CHK && usable) |-> need_ff != '0)
      else $error("grant attempted with nothing left to allocate");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A1_CHK || state_ff == S_A2_CHK || state_ff == S_R_CHK)
      |-> CNT_W'(idx_ff) < entries_ff)
      else $error("scan index beyond used entries");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE)
      else $error("command popped without being processed");

endmodule

### hdl/extent_free_space_allocator_unit.sv
`timescale 1ns / 1ps
// Extent free-space allocator top level: config registers, front end, queue, engine.
// Release scans the used entries; allocate scans entries in each of two passes,
// first summing free space and then granting. Throughput is one request at a time in
// the engine, set by the entry-by-entry table scan; the queue holds two more.
// Synchronous reset empties the table, clears the free total and loads the register defaults.
module extent_free_space_allocator_unit #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  efsa_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output efsa_pkg::rsp_item_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   efsa_pkg::cfg_type cfg_ff;
   efsa_pkg::cmd_type push_cmd, pop_cmd;
   logic              q_ready, q_push, q_pop, q_valid, cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;
   assign prdata = paddr[2] ? {8'b0, cfg_ff.first_free_block} : {7'b0, cfg_ff.volume_blocks};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume_blocks    <= efsa_pkg::VOLUME_RESET;
         cfg_ff.first_free_block <= efsa_pkg::FIRST_FREE_RESET;
      end else if (cfg_we) begin
         if (paddr[2]) cfg_ff.first_free_block <= pwdata[efsa_pkg::ADDR_W-1:0];
         else cfg_ff.volume_blocks <= pwdata[efsa_pkg::LEN_W-1:0];
      end
   end

   efsa_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   efsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (pop_cmd)
   );

   efsa_engine #(.MAX_EXTENTS(MAX_EXTENTS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for extent_free_space_allocator_unit: directed and random requests,
// a scoreboard that predicts every result beat, random stalls on both channels.
// Depends on efsa_pkg and the allocator RTL.
module testbench;

   localparam int         AW          = efsa_pkg::ADDR_W;
   localparam int         LW          = efsa_pkg::LEN_W;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam logic [2:0] ADDR_VOLUME = 3'd0;
   localparam logic [2:0] ADDR_FIRST  = 3'd4;
   localparam int         TABLE_SIZE  = 64;
   localparam int         DRAIN_WAIT  = 300;
   localparam int         STALL_LIMIT = 20000;

   class alloc_scoreboard;
      logic [AW-1:0]          ext_start[TABLE_SIZE];
      logic [LW-1:0]          ext_len[TABLE_SIZE];
      bit                     ext_ok[TABLE_SIZE];
      int                     entries;
      logic [LW-1:0]          free_blocks;
      logic [LW-1:0]          volume;
      logic [AW-1:0]          first_free;
      efsa_pkg::rsp_item_type expected[$];
      logic [AW-1:0]          held_start[$];
      logic [LW-1:0]          held_len[$];
      int                     errors;

      function void reset_state();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            ext_start[i] = '0;
            ext_len[i] = '0;
            ext_ok[i] = 0;
         end
         entries = 0;
         free_blocks = '0;
         volume = efsa_pkg::VOLUME_RESET;
         first_free = efsa_pkg::FIRST_FREE_RESET;
         errors = 0;
      endfunction

      function void push_beat(logic [2:0] st, logic [AW-1:0] gs,
                              logic [LW-1:0] gc, logic lst);
         efsa_pkg::rsp_item_type b;
         b.status = st;
         b.granted_start = gs;
         b.granted_count = gc;
         b.last = lst;
         b.free_remaining = free_blocks;
         expected.push_back(b);
      endfunction

      function bit usable(int e, logic [LW-1:0] minc);
         return ext_ok[e] && ext_len[e] != 0 && ext_len[e] >= minc;
      endfunction

      function void allocate(logic [LW-1:0] need, logic [LW-1:0] minc);
         int                     n;
         logic [31:0]            sum;
         logic [LW-1:0]          take;
         efsa_pkg::rsp_item_type grants[$];
         efsa_pkg::rsp_item_type b;
         n = entries;
         sum = '0;
         if (need == 0) begin
            push_beat(efsa_pkg::STATUS_OK, '0, '0, 1'b1);
            return;
         end
         if (need > free_blocks || need < minc) begin
            push_beat(efsa_pkg::STATUS_NO_SPACE, '0, '0, 1'b1);
            return;
         end
         for (int e = n - 1; e >= 0 && sum < need; e--)
            if (usable(e, minc)) sum += ext_len[e];
         if (sum < need) begin
            push_beat(efsa_pkg::STATUS_FRAG, '0, '0, 1'b1);
            return;
         end
         for (int e = n - 1; e >= 0 && need > 0; e--) begin
            if (!usable(e, minc)) continue;
            take = (ext_len[e] <= need) ? ext_len[e] : need;
            b = '0;
            b.status = efsa_pkg::STATUS_OK;
            b.granted_start = ext_start[e];
            b.granted_count = take;
            grants.push_back(b);
            held_start.push_back(ext_start[e]);
            held_len.push_back(take);
            if (take == ext_len[e]) begin
               ext_start[e] = '0;
               ext_len[e] = '0;
               ext_ok[e] = 0;
            end else begin
               ext_start[e] = ext_start[e] + take[AW-1:0];
               ext_len[e] = ext_len[e] - take;
            end
            free_blocks = (free_blocks >= take) ? free_blocks - take : '0;
            need = need - take;
         end
         foreach (grants[j]) begin
            grants[j].last = (j == grants.size() - 1);
            grants[j].free_remaining = free_blocks;
            expected.push_back(grants[j]);
         end
      endfunction

      function logic [2:0] release_range(logic [AW-1:0] start, logic [LW-1:0] cnt);
         logic [25:0] endx;
         logic [25:0] ee;
         logic [25:0] total;
         int          i;
         endx = {2'b00, start} + {1'b0, cnt};
         if (endx > {1'b0, volume}) return efsa_pkg::STATUS_RANGE;
         if (cnt == 0) return efsa_pkg::STATUS_OK;
         for (i = 0; i < entries; i++) begin
            ee = {2'b00, ext_start[i]} + {1'b0, ext_len[i]};
            if (ext_ok[i] && ext_len[i] != 0 && {2'b00, start} < ee
                && {2'b00, ext_start[i]} < endx)
               return efsa_pkg::STATUS_OVERLAP;
         end
         for (i = 0; i < entries; i++) begin
            if (ext_ok[i] && {2'b00, ext_start[i]} == endx) begin
               ext_start[i] = start;
               ext_len[i] = ext_len[i] + cnt;
               break;
            end
            if (!ext_ok[i]) begin
               ext_start[i] = start;
               ext_len[i] = cnt;
               ext_ok[i] = 1;
               break;
            end
         end
         if (i == entries) begin
            if (entries >= TABLE_SIZE) return efsa_pkg::STATUS_FULL;
            ext_start[i] = start;
            ext_len[i] = cnt;
            ext_ok[i] = 1;
            entries++;
         end
         total = {1'b0, free_blocks} + {1'b0, cnt};
         free_blocks = total[25] ? '1 : total[LW-1:0];
         return efsa_pkg::STATUS_OK;
      endfunction

      function void format_table();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            ext_start[i] = '0;
            ext_len[i] = '0;
            ext_ok[i] = 0;
         end
         ext_start[0] = first_free;
         if ({1'b0, first_free} < volume) begin
            ext_len[0] = volume - {1'b0, first_free};
            ext_ok[0] = 1;
         end
         free_blocks = ext_len[0];
         entries = 1;
      endfunction

      function void note_request(efsa_pkg::req_item_type r);
         logic [2:0] st;
         case (r.req_type)
            efsa_pkg::REQ_ALLOC: allocate(r.block_count, r.min_contiguous);
            efsa_pkg::REQ_RELEASE: begin
               st = release_range(r.start_block, r.block_count);
               push_beat(st, '0, '0, 1'b1);
            end
            efsa_pkg::REQ_FORMAT: begin
               format_table();
               push_beat(efsa_pkg::STATUS_OK, '0, '0, 1'b1);
            end
            default: push_beat(efsa_pkg::STATUS_RANGE, '0, '0, 1'b1);
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_beat(efsa_pkg::rsp_item_type got);
         efsa_pkg::rsp_item_type want;
         if (expected.size() == 0) begin
            report($sformatf("unexpected beat %p", got));
            return;
         end
         want = expected.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.granted_start !== want.granted_start)
            report($sformatf("granted_start %0d, want %0d", got.granted_start,
                             want.granted_start));
         if (got.granted_count !== want.granted_count)
            report($sformatf("granted_count %0d, want %0d", got.granted_count,
                             want.granted_count));
         if (got.last !== want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
         if (got.free_remaining !== want.free_remaining)
            report($sformatf("free_remaining %0d, want %0d", got.free_remaining,
                             want.free_remaining));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   efsa_pkg::req_item_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   efsa_pkg::rsp_item_type rsp_data;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [2:0]             paddr;
   logic [31:0]            pwdata;
   logic [31:0]            prdata;
   logic                   pready;

   alloc_scoreboard sb;
   int              send_idle_pct;
   int              rsp_stall_pct;
   int              quiet_cycles;

   extent_free_space_allocator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task send_request(logic [1:0] kind, logic [LW-1:0] cnt, logic [LW-1:0] minc,
                     logic [AW-1:0] start);
      efsa_pkg::req_item_type r;
      r.req_type = kind;
      r.block_count = cnt;
      r.min_contiguous = minc;
      r.start_block = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task write_csr(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_VOLUME) sb.volume = value[LW-1:0];
      else sb.first_free = value[AW-1:0];
      @(negedge clock);
   endtask

   task send_random();
      int            pick;
      int            idx;
      logic [LW-1:0] part;
      pick = $urandom_range(99);
      if (pick < 45) begin
         send_request(efsa_pkg::REQ_ALLOC,
                      LW'($urandom_range(1, (pick < 5) ? 4000 : 64)),
                      LW'($urandom_range(0, 8)), '0);
      end else if (pick < 82 && sb.held_start.size() != 0) begin
         idx = $urandom_range(sb.held_start.size() - 1);
         part = ($urandom_range(3) == 0) ? LW'($urandom_range(1, sb.held_len[idx]))
                                         : sb.held_len[idx];
         send_request(efsa_pkg::REQ_RELEASE, part, '0, sb.held_start[idx]);
         sb.held_start.delete(idx);
         sb.held_len.delete(idx);
      end else if (pick < 86) begin
         sb.held_start.delete();
         sb.held_len.delete();
         send_request(efsa_pkg::REQ_FORMAT, LW'($urandom()), LW'($urandom()),
                      AW'($urandom()));
      end else begin
         send_request(2'($urandom_range(3)), LW'($urandom()), LW'($urandom()),
                      AW'($urandom()));
      end
   endtask

   logic [LW-1:0] phase_volume[4];
   logic [AW-1:0] phase_first[4];

   initial begin
      sb = new();
      sb.reset_state();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet_cycles = 0;
      send_idle_pct = 17;
      rsp_stall_pct = 64;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(efsa_pkg::REQ_ALLOC, 25'd5, '0, '0);
      send_request(efsa_pkg::REQ_RELEASE, 25'd1, '0, 24'd0);
      send_request(efsa_pkg::REQ_FORMAT, '0, '0, '0);
      send_request(efsa_pkg::REQ_ALLOC, '0, '0, '0);
      send_request(efsa_pkg::REQ_ALLOC, 25'd100, '0, '0);
      send_request(efsa_pkg::REQ_ALLOC, 25'd10, 25'd20, '0);
      send_request(efsa_pkg::REQ_ALLOC, 25'h1000000, 25'h1000000, '0);
      send_request(efsa_pkg::REQ_RELEASE, 25'd1, '0, 24'd0);
      drain();
      send_request(efsa_pkg::REQ_ALLOC, sb.free_blocks, 25'd2, '0);
      send_request(efsa_pkg::REQ_RELEASE, 25'd10, '0, 24'd200);
      send_request(efsa_pkg::REQ_RELEASE, 25'd2, '0, 24'hFFFFFF);
      send_request(efsa_pkg::REQ_RELEASE, '0, '0, 24'd50);
      send_request(REQ_UNKNOWN, 25'h1FFFFFF, 25'h1FFFFFF, 24'hFFFFFF);
      send_request(efsa_pkg::REQ_RELEASE, 25'd100, '0, 24'd1);
      send_request(efsa_pkg::REQ_FORMAT, '0, '0, '0);
      send_request(efsa_pkg::REQ_ALLOC, 25'd200, '0, '0);
      for (int b = 2; b <= 130; b += 2)
         send_request(efsa_pkg::REQ_RELEASE, 25'd1, '0, AW'(b));
      send_request(efsa_pkg::REQ_ALLOC, 25'd30, 25'd1, '0);
      drain();

      phase_volume = '{25'd4096, 25'd1, 25'h1000000, 25'd600};
      phase_first = '{24'd16, 24'hFFFFFF, 24'd0, 24'd1};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 0) ? 17 : (p == 1) ? 64 : 0;
         rsp_stall_pct = (p == 0) ? 64 : (p == 1) ? 17 : 0;
         write_csr(ADDR_VOLUME, {7'b0, phase_volume[p]});
         write_csr(ADDR_FIRST, {8'b0, phase_first[p]});
         sb.held_start.delete();
         sb.held_len.delete();
         send_request(efsa_pkg::REQ_FORMAT, '0, '0, '0);
         repeat ((p == 1) ? 4 : 8) send_random();
         drain();
      end

      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

### files.f
hdl/efsa_pkg.sv
hdl/efsa_front.sv
hdl/efsa_queue.sv
hdl/efsa_engine.sv
hdl/extent_free_space_allocator_unit.sv
dv/testbench.sv
